// ----- rtl/core/wcls_pkg.sv -----
// ----------------------------------------------------------------------------
// wcls_pkg
// Types, constants, word ROM and sentence tables for the word clock letter
// sequencer.
// ----------------------------------------------------------------------------
package wcls_pkg;

   localparam int LETTER_COUNT = 110;
   localparam int MAX_RESULTS  = 23;
   localparam int WORD_COUNT   = 23;
   localparam int WORD_SLOTS   = 6;
   localparam int CSR_ADDR_W   = 3;

   // minute rounding: (2m+5)/10 as reciprocal multiply
   localparam logic [15:0] DIV10_MUL   = 16'd205;
   localparam int          DIV10_SHIFT = 11;

   localparam logic [5:0] HOURS_PER_DIAL = 6'd12;

   // register indexes, taken from paddr[2]
   localparam logic CSR_IDX_FADE_STEP    = 1'b0;
   localparam logic CSR_IDX_REVEAL_SHIFT = 1'b1;

   localparam logic [7:0] FADE_STEP_RST    = 8'd4;
   localparam logic [3:0] REVEAL_SHIFT_RST = 4'd4;
   localparam logic [7:0] LEVEL_RST        = 8'd255;
   localparam logic [6:0] LIMIT_RST        = 7'd127;

   typedef struct packed {
      logic       power_on;
      logic       time_synced;
      logic [4:0] hour_now;
      logic [5:0] minute_now;
      logic [7:0] brightness_in;
   } req_type;

   typedef struct packed {
      logic       letter_valid;
      logic [6:0] letter_pos;
      logic       last_letter;
      logic [7:0] brightness_out;
      logic [1:0] mode_out;
   } rsp_type;

   typedef enum logic [3:0] {
      MODE_BOOT    = 4'b0001,
      MODE_BLANK   = 4'b0010,
      MODE_DISPLAY = 4'b0100,
      MODE_FADE    = 4'b1000
   } mode_type;

   localparam logic [1:0] MODE_CODE_BOOT    = 2'd0;
   localparam logic [1:0] MODE_CODE_BLANK   = 2'd1;
   localparam logic [1:0] MODE_CODE_DISPLAY = 2'd2;
   localparam logic [1:0] MODE_CODE_FADE    = 2'd3;

   // microcode
   typedef enum logic [1:0] {
      OP_NOP    = 2'd0,
      OP_UPDATE = 2'd1,
      OP_EMIT   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      C_ALWAYS    = 2'd0,
      C_REQ_FIRE  = 2'd1,
      C_EMIT_DONE = 2'd2
   } cond_type;

   typedef logic [1:0] pc_type;

   localparam pc_type PC_WAIT   = 2'd0;
   localparam pc_type PC_UPDATE = 2'd1;
   localparam pc_type PC_EMIT   = 2'd2;
   localparam pc_type PC_TRAP   = 2'd3;

   typedef struct packed {
      op_type   op;
      logic     req_rdy;
      cond_type cond;
      pc_type   tgt_t;
      pc_type   tgt_f;
   } ctrl_word_type;

   localparam ctrl_word_type UCODE [4] = '{
      '{OP_NOP,    1'b1, C_REQ_FIRE,  PC_UPDATE, PC_WAIT},
      '{OP_UPDATE, 1'b0, C_ALWAYS,    PC_EMIT,   PC_EMIT},
      '{OP_EMIT,   1'b0, C_EMIT_DONE, PC_WAIT,   PC_EMIT},
      '{OP_NOP,    1'b0, C_ALWAYS,    PC_WAIT,   PC_WAIT}
   };

   // word codes
   localparam logic [4:0] W_IT      = 5'd0;
   localparam logic [4:0] W_IS      = 5'd1;
   localparam logic [4:0] W_FIVE    = 5'd2;
   localparam logic [4:0] W_TEN     = 5'd3;
   localparam logic [4:0] W_TO_A    = 5'd4;
   localparam logic [4:0] W_PAST_A  = 5'd5;
   localparam logic [4:0] W_QUARTER = 5'd6;
   localparam logic [4:0] W_HALF    = 5'd7;
   localparam logic [4:0] W_PAST_B  = 5'd8;
   localparam logic [4:0] W_TO_B    = 5'd9;
   localparam logic [4:0] W_OCLOCK  = 5'd10;
   localparam logic [4:0] W_HOUR1   = 5'd11;

   localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
      3'd3, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd6
   };

   localparam logic [6:0] LETTER_ROM [WORD_COUNT*WORD_SLOTS] = '{
      7'd109, 7'd108, 7'd107, 7'd0,   7'd0,   7'd0,
      7'd105, 7'd104, 7'd0,   7'd0,   7'd0,   7'd0,
      7'd102, 7'd101, 7'd100, 7'd99,  7'd0,   7'd0,
      7'd88,  7'd89,  7'd90,  7'd91,  7'd0,   7'd0,
      7'd95,  7'd96,  7'd97,  7'd98,  7'd0,   7'd0,
      7'd87,  7'd86,  7'd85,  7'd84,  7'd0,   7'd0,
      7'd81,  7'd80,  7'd79,  7'd78,  7'd77,  7'd0,
      7'd66,  7'd67,  7'd68,  7'd69,  7'd0,   7'd0,
      7'd73,  7'd74,  7'd75,  7'd76,  7'd0,   7'd0,
      7'd65,  7'd64,  7'd63,  7'd62,  7'd0,   7'd0,
      7'd8,   7'd9,   7'd10,  7'd0,   7'd0,   7'd0,
      7'd58,  7'd57,  7'd56,  7'd0,   7'd0,   7'd0,
      7'd44,  7'd45,  7'd46,  7'd47,  7'd0,   7'd0,
      7'd51,  7'd52,  7'd53,  7'd54,  7'd0,   7'd0,
      7'd43,  7'd42,  7'd41,  7'd40,  7'd0,   7'd0,
      7'd39,  7'd38,  7'd37,  7'd36,  7'd0,   7'd0,
      7'd35,  7'd34,  7'd33,  7'd0,   7'd0,   7'd0,
      7'd22,  7'd23,  7'd24,  7'd25,  7'd26,  7'd0,
      7'd21,  7'd20,  7'd19,  7'd18,  7'd0,   7'd0,
      7'd28,  7'd29,  7'd30,  7'd31,  7'd32,  7'd0,
      7'd18,  7'd17,  7'd16,  7'd15,  7'd0,   7'd0,
      7'd13,  7'd12,  7'd11,  7'd0,   7'd0,   7'd0,
      7'd0,   7'd1,   7'd2,   7'd3,   7'd4,   7'd5
   };

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] c;
      case (m)
         MODE_BOOT:    c = MODE_CODE_BOOT;
         MODE_BLANK:   c = MODE_CODE_BLANK;
         MODE_DISPLAY: c = MODE_CODE_DISPLAY;
         MODE_FADE:    c = MODE_CODE_FADE;
         default:      c = MODE_CODE_BOOT;
      endcase
      return c;
   endfunction

   // hour mod 12, zero shows as twelve; v stays below 36
   function automatic logic [4:0] hour_word(input logic [5:0] v);
      logic [5:0] m;
      if (v >= 6'(2 * HOURS_PER_DIAL)) begin
         m = v - 6'(2 * HOURS_PER_DIAL);
      end else if (v >= HOURS_PER_DIAL) begin
         m = v - HOURS_PER_DIAL;
      end else begin
         m = v;
      end
      if (m == 6'd0) begin
         return W_HOUR1 + 5'd11;
      end
      return W_HOUR1 + 5'(m) - 5'd1;
   endfunction

   function automatic logic [2:0] word_count(input logic [3:0] st);
      logic [2:0] n;
      case (st) inside
         4'd0, 4'd6, 4'd12:                     n = 3'd4;
         4'd1, 4'd2, 4'd3, 4'd9, 4'd10, 4'd11:  n = 3'd5;
         4'd4, 4'd5, 4'd7, 4'd8:                n = 3'd6;
         default:                               n = 3'd2;
      endcase
      return n;
   endfunction

   function automatic logic [4:0] sentence_word(input logic [3:0] st, input logic [2:0] slot,
                                                input logic [4:0] hr);
      logic       late;
      logic [4:0] hw_cur;
      logic [4:0] hw_nxt;
      logic [4:0] past;
      logic [4:0] to;
      logic [4:0] w2;
      logic [4:0] w3;
      logic [4:0] w4;
      logic [4:0] w5;
      logic [4:0] w;
      late   = hr > 5'd6;
      hw_cur = hour_word({1'b0, hr});
      hw_nxt = hour_word({1'b0, hr} + 6'd1);
      past   = late ? W_PAST_B : W_PAST_A;
      to     = late ? W_TO_B : W_TO_A;
      w2 = W_IT;
      w3 = W_IT;
      w4 = W_IT;
      w5 = W_IT;
      case (st)
         4'd0: begin
            w2 = hw_cur; w3 = W_OCLOCK;
         end
         4'd1: begin
            w2 = W_FIVE; w3 = past; w4 = hw_cur;
         end
         4'd2: begin
            w2 = W_TEN; w3 = past; w4 = hw_cur;
         end
         4'd3: begin
            w2 = W_QUARTER; w3 = W_PAST_B; w4 = hw_cur;
         end
         4'd4: begin
            w2 = W_TEN; w3 = W_TO_A; w4 = W_HALF; w5 = hw_nxt;
         end
         4'd5: begin
            w2 = W_FIVE; w3 = W_TO_A; w4 = W_HALF; w5 = hw_nxt;
         end
         4'd6: begin
            w2 = W_HALF; w3 = hw_nxt;
         end
         4'd7: begin
            w2 = W_FIVE; w3 = W_PAST_A; w4 = W_HALF; w5 = hw_nxt;
         end
         4'd8: begin
            w2 = W_TEN; w3 = W_PAST_A; w4 = W_HALF; w5 = hw_nxt;
         end
         4'd9: begin
            w2 = W_QUARTER; w3 = W_TO_B; w4 = hw_nxt;
         end
         4'd10: begin
            w2 = W_TEN; w3 = to; w4 = hw_nxt;
         end
         4'd11: begin
            w2 = W_FIVE; w3 = to; w4 = hw_nxt;
         end
         4'd12: begin
            w2 = hw_nxt; w3 = W_OCLOCK;
         end
         default: begin
         end
      endcase
      case (slot)
         3'd0:    w = W_IT;
         3'd1:    w = W_IS;
         3'd2:    w = w2;
         3'd3:    w = w3;
         3'd4:    w = w4;
         3'd5:    w = w5;
         default: w = W_IT;
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/word_clock_letter_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// word_clock_letter_sequencer_top
// Per display tick: mode update, brightness fade and serial emission of the
// lit letter positions, run by a three-step microcode sequencer.
// ----------------------------------------------------------------------------
// After the request transaction the sequencer runs the update step; the emit
// step then registers the results of the tick, N of them (1..23), one result per
// cycle from the word and letter ROMs while the output is free (rsp_ready).
// A new request is taken in the wait step, while the last result may still wait.
// Synchronous reset: sequencer to wait, mode boot, level 255, registers 4/4.
module word_clock_letter_sequencer_top
   import wcls_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [7:0]    fade_step_ff, fade_step_in;
   logic [3:0]    reveal_shift_ff, reveal_shift_in;
   pc_type        pc_ff, pc_in;
   req_type       req_ff;
   mode_type      mode_ff, mode_in;
   logic [15:0]   tick_ff, tick_in;
   logic [3:0]    shown_step_ff, shown_step_in;
   logic [4:0]    shown_hour_ff, shown_hour_in;
   logic [6:0]    limit_ff, limit_in;
   logic          words_ff, words_in;
   logic [7:0]    level_ff, level_in;
   logic [2:0]    slot_ff, slot_in;
   logic [2:0]    letter_ff, letter_in;
   logic [4:0]    drawn_ff, drawn_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   ctrl_word_type uw;
   logic          req_fire;
   logic          out_free;
   logic          csr_wr;
   logic [7:0]    mins2;
   logic [15:0]   prod;
   logic [3:0]    cur_step;
   logic [15:0]   mask;
   logic [2:0]    nw;
   logic [4:0]    cur_word;
   logic [2:0]    cur_len;
   logic [7:0]    rom_idx;
   logic          cur_ok;
   logic          last_in_word;
   logic [4:0]    drawn_nx;
   logic          next_ok;
   logic          emit_last;
   logic          emit_fire;
   logic          cond_hit;

   assign uw        = UCODE[pc_ff];
   assign req_ready = uw.req_rdy;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      case (paddr[2])
         CSR_IDX_FADE_STEP:    prdata = {24'd0, fade_step_ff};
         CSR_IDX_REVEAL_SHIFT: prdata = {28'd0, reveal_shift_ff};
         default:              prdata = 32'd0;
      endcase
   end

   // step = (2m+5)/10
   assign mins2    = {1'b0, req_ff.minute_now, 1'b0} + 8'd5;
   assign prod     = {8'd0, mins2} * DIV10_MUL;
   assign cur_step = 4'(prod >> DIV10_SHIFT);
   assign mask     = (16'd1 << reveal_shift_ff) - 16'd1;

   assign nw           = word_count(shown_step_ff);
   assign cur_word     = sentence_word(shown_step_ff, slot_ff, shown_hour_ff);
   assign cur_len      = WORD_LEN[cur_word];
   assign rom_idx      = 8'({3'd0, cur_word} * 8'(WORD_SLOTS)) + {5'd0, letter_ff};
   assign cur_ok       = words_ff && (slot_ff < nw) && ({2'd0, drawn_ff} < limit_ff);
   assign last_in_word = (letter_ff + 3'd1) == cur_len;
   assign drawn_nx     = drawn_ff + 5'd1;
   assign next_ok      = (!last_in_word || ((slot_ff + 3'd1) < nw)) &&
                         ({2'd0, drawn_nx} < limit_ff);
   assign emit_last    = !cur_ok || !next_ok;
   assign emit_fire    = (uw.op == OP_EMIT) && out_free;

   always_comb begin
      case (uw.cond)
         C_ALWAYS:    cond_hit = 1'b1;
         C_REQ_FIRE:  cond_hit = req_fire;
         C_EMIT_DONE: cond_hit = emit_fire && emit_last;
         default:     cond_hit = 1'b0;
      endcase
      pc_in = cond_hit ? uw.tgt_t : uw.tgt_f;
   end

   always_comb begin
      fade_step_in    = fade_step_ff;
      reveal_shift_in = reveal_shift_ff;
      if (csr_wr) begin
         case (paddr[2])
            CSR_IDX_FADE_STEP:    fade_step_in = pwdata[7:0];
            CSR_IDX_REVEAL_SHIFT: reveal_shift_in = pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      tick_in       = tick_ff;
      shown_step_in = shown_step_ff;
      shown_hour_in = shown_hour_ff;
      limit_in      = limit_ff;
      words_in      = words_ff;
      level_in      = level_ff;
      slot_in       = slot_ff;
      letter_in     = letter_ff;
      drawn_in      = drawn_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      case (uw.op)
         OP_UPDATE: begin
            slot_in   = 3'd0;
            letter_in = 3'd0;
            drawn_in  = 5'd0;
            tick_in   = tick_ff + 16'd1;
            case (mode_ff)
               MODE_BOOT: begin
                  if (req_ff.time_synced) begin
                     mode_in = MODE_BLANK;
                  end
               end
               MODE_BLANK: begin
                  if (req_ff.power_on) begin
                     mode_in       = MODE_DISPLAY;
                     limit_in      = 7'd0;
                     shown_step_in = cur_step;
                     shown_hour_in = req_ff.hour_now;
                     words_in      = 1'b1;
                  end
               end
               MODE_DISPLAY: begin
                  level_in = req_ff.brightness_in;
                  if ((limit_ff < 7'(LETTER_COUNT)) && ((tick_ff & mask) == 16'd0)) begin
                     limit_in = limit_ff + 7'd1;
                  end
                  if (!req_ff.power_on || (cur_step != shown_step_ff)) begin
                     mode_in = MODE_FADE;
                  end
               end
               MODE_FADE: begin
                  if (level_ff > fade_step_ff) begin
                     level_in = level_ff - fade_step_ff;
                  end else begin
                     words_in = 1'b0;
                     mode_in  = MODE_BLANK;
                  end
               end
               default: mode_in = MODE_BOOT;
            endcase
         end
         OP_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in          = 1'b1;
               rsp_in.brightness_out = level_ff;
               rsp_in.mode_out       = mode_code(mode_ff);
               rsp_in.last_letter    = emit_last;
               if (cur_ok) begin
                  rsp_in.letter_valid = 1'b1;
                  rsp_in.letter_pos   = LETTER_ROM[rom_idx];
                  drawn_in            = drawn_nx;
                  if (last_in_word) begin
                     slot_in   = slot_ff + 3'd1;
                     letter_in = 3'd0;
                  end else begin
                     letter_in = letter_ff + 3'd1;
                  end
               end else begin
                  rsp_in.letter_valid = 1'b0;
                  rsp_in.letter_pos   = 7'd0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_step_ff    <= FADE_STEP_RST;
         reveal_shift_ff <= REVEAL_SHIFT_RST;
         pc_ff           <= PC_WAIT;
         mode_ff         <= MODE_BOOT;
         tick_ff         <= 16'd0;
         shown_step_ff   <= 4'd0;
         shown_hour_ff   <= 5'd0;
         limit_ff        <= LIMIT_RST;
         words_ff        <= 1'b0;
         level_ff        <= LEVEL_RST;
         slot_ff         <= 3'd0;
         letter_ff       <= 3'd0;
         drawn_ff        <= 5'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fade_step_ff    <= fade_step_in;
         reveal_shift_ff <= reveal_shift_in;
         pc_ff           <= pc_in;
         mode_ff         <= mode_in;
         tick_ff         <= tick_in;
         shown_step_ff   <= shown_step_in;
         shown_hour_ff   <= shown_hour_in;
         limit_ff        <= limit_in;
         words_ff        <= words_in;
         level_ff        <= level_in;
         slot_ff         <= slot_in;
         letter_ff       <= letter_in;
         drawn_ff        <= drawn_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> pc_ff == PC_UPDATE)
      else $error("request transaction not followed by update step");

   a_last_to_wait: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_last) |=> pc_ff == PC_WAIT)
      else $error("sequencer did not return to wait after last result");

   a_blank_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.letter_valid) |-> rsp_ff.last_letter)
      else $error("empty result not marked last");

   a_drawn_bound: assert property (@(posedge clock) disable iff (reset)
      drawn_ff <= 5'(MAX_RESULTS))
      else $error("letter count exceeds sentence maximum");

endmodule
